/* src/zfn_pkg.sv */
package zfn_pkg;

  // sizes of the data path
  localparam int unsigned MaxVectors = 64;
  localparam int unsigned Dims       = 7;
  localparam int unsigned ValW       = 24;
  localparam int unsigned FracW      = 12;
  localparam int unsigned SumW       = 31;
  localparam int unsigned DiffW      = ValW + 1;
  localparam int unsigned SqW        = 2 * DiffW;
  localparam int unsigned DvdW       = SqW + 6;
  localparam int unsigned DvsW       = 25;
  localparam int unsigned VarW       = 49;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  // what a running division produces
  typedef enum logic [1:0] {
    SEL_MEAN = 2'd0,
    SEL_VAR  = 2'd1,
    SEL_NORM = 2'd2
  } div_sel_e;

  // control from the sequencer to every lane
  typedef struct packed {
    logic     wr;
    logic     sq;
    logic     acc;
    logic     div_go;
    div_sel_e sel;
    logic     sqrt_go;
    logic     clear;
  } zfn_ctrl_t;

  // status from a lane
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } zfn_stat_t;

  typedef struct packed {
    logic signed [ValW-1:0] dim0_value;
    logic signed [ValW-1:0] dim1_value;
    logic signed [ValW-1:0] dim2_value;
    logic signed [ValW-1:0] dim3_value;
    logic signed [ValW-1:0] dim4_value;
    logic signed [ValW-1:0] dim5_value;
    logic signed [ValW-1:0] dim6_value;
    logic                   set_last;
  } zfn_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] norm0;
    logic signed [ValW-1:0] norm1;
    logic signed [ValW-1:0] norm2;
    logic signed [ValW-1:0] norm3;
    logic signed [ValW-1:0] norm4;
    logic signed [ValW-1:0] norm5;
    logic signed [ValW-1:0] norm6;
    logic                   result_last;
  } zfn_out_t;

endpackage

/* src/zfn_ram.sv */
module zfn_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/zfn_div.sv */
module zfn_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [zfn_pkg::DvdW-1:0]     dvd_i,
  input  logic [zfn_pkg::DvsW-1:0]     dvs_i,
  output logic                         done_o,
  output logic [zfn_pkg::DvdW-1:0]     quo_o
);
  import zfn_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvsW-1:0] rem_q, dvs_q, rem_d;
  logic [DvdW-1:0] quo_q;
  logic [DvsW:0]   part, part_sub;
  logic            ge;

  // one restoring step per cycle
  assign part     = {rem_q, quo_q[DvdW-1]};
  assign part_sub = part - {1'b0, dvs_q};
  assign ge       = part >= {1'b0, dvs_q};
  assign rem_d    = ge ? part_sub[DvsW-1:0] : part[DvsW-1:0];

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(DvdW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DvdW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* src/zfn_lane.sv */
module zfn_lane #(
  parameter int unsigned MaxVectors = zfn_pkg::MaxVectors,
  localparam int unsigned AddrW = (MaxVectors > 1) ? $clog2(MaxVectors) : 1,
  localparam int unsigned CntW  = $clog2(MaxVectors + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  zfn_pkg::zfn_ctrl_t                ctrl_i,
  input  logic [AddrW-1:0]                  addr_i,
  input  logic signed [zfn_pkg::ValW-1:0]   value_i,
  input  logic [CntW-1:0]                   count_i,
  output zfn_pkg::zfn_stat_t                stat_o,
  output logic signed [zfn_pkg::ValW-1:0]   norm_o
);
  import zfn_pkg::*;

  logic [ValW-1:0]        rdata;
  logic signed [SumW-1:0] sum_q;
  logic [SumW-1:0]        sum_mag;
  logic signed [ValW-1:0] mean_q;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]       diff_mag;
  logic [SqW-1:0]         sq_q;
  logic [DvdW-1:0]        acc_q;
  logic [VarW-1:0]        var_q;
  logic [DvsW-1:0]        divisor_q;
  logic                   sign_q;
  div_sel_e               sel_q;
  logic [DvdW-1:0]        dvd, quo;
  logic [DvsW-1:0]        dvs;
  logic                   div_done;

  // stored vectors of this dimension
  zfn_ram #(
    .Width (ValW),
    .Depth (MaxVectors)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr),
    .waddr_i (addr_i),
    .wdata_i (value_i),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  // deviation of the read value from the mean
  assign diff     = DiffW'($signed(rdata)) - DiffW'(mean_q);
  assign diff_mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign sum_mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  // running sum and sum of squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      sum_q <= '0;
      acc_q <= '0;
    end else begin
      if (ctrl_i.wr) begin
        sum_q <= sum_q + SumW'(value_i);
      end
      if (ctrl_i.acc) begin
        acc_q <= acc_q + DvdW'(sq_q);
      end
    end
  end

  // squared deviation, registered before the accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sq) begin
      sq_q <= diff_mag * diff_mag;
    end
  end

  // divider operand select
  always_comb begin
    case (ctrl_i.sel)
      SEL_MEAN: begin
        dvd = DvdW'(sum_mag);
        dvs = DvsW'(count_i);
      end
      SEL_VAR: begin
        dvd = acc_q;
        dvs = DvsW'(count_i);
      end
      SEL_NORM: begin
        dvd = DvdW'({diff_mag, {FracW{1'b0}}});
        dvs = divisor_q;
      end
      default: begin
        dvd = '0;
        dvs = DvsW'(1);
      end
    endcase
  end

  zfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.div_go),
    .dvd_i   (dvd),
    .dvs_i   (dvs),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // remember what the divider is working on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_MEAN;
    end else if (ctrl_i.div_go) begin
      sel_q <= ctrl_i.sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_go) begin
      sign_q <= (ctrl_i.sel == SEL_NORM) ? diff[DiffW-1] : sum_q[SumW-1];
    end
  end

  // capture mean and variance
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (sel_q)
        SEL_MEAN: mean_q <= sign_q ? ValW'(-quo[ValW-1:0]) : quo[ValW-1:0];
        SEL_VAR:  var_q  <= quo[VarW-1:0];
        default:  ;
      endcase
    end
  end

  // bit-pair square root of the variance
  logic [VarW-1:0] sv_q, sr_q, sb_q, trial;
  logic            sq_busy_q, sqrt_done_q, sge;

  assign trial = sr_q + sb_q;
  assign sge   = sv_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q   <= 1'b0;
      sqrt_done_q <= 1'b0;
    end else begin
      sqrt_done_q <= sq_busy_q && sb_q[0];
      if (ctrl_i.sqrt_go) begin
        sq_busy_q <= 1'b1;
      end else if (sq_busy_q && sb_q[0]) begin
        sq_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqrt_go) begin
      sv_q <= var_q;
      sr_q <= '0;
      sb_q <= {1'b1, {(VarW-1){1'b0}}};
    end else if (sq_busy_q) begin
      if (sge) begin
        sv_q <= sv_q - trial;
        sr_q <= (sr_q >> 1) + sb_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sb_q <= sb_q >> 2;
    end
  end

  // divisor floored at one lsb
  always_ff @(posedge clk_i) begin
    if (sqrt_done_q) begin
      divisor_q <= (sr_q == '0) ? DvsW'(1) : sr_q[DvsW-1:0];
    end
  end

  // signed and saturated quotient
  always_comb begin
    if (!sign_q) begin
      norm_o = (quo > DvdW'(ValMax)) ? ValMax : quo[ValW-1:0];
    end else begin
      norm_o = (quo > DvdW'(unsigned'(ValMax)) + DvdW'(1)) ? ValMin :
               ValW'(-quo[ValW-1:0]);
    end
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done_q;

endmodule

/* src/zfn_merge.sv */
module zfn_merge (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          emit_i,
  input  logic                                          last_i,
  input  logic [zfn_pkg::Dims-1:0][zfn_pkg::ValW-1:0]   norm_i,
  output logic                                          res_valid_o,
  output zfn_pkg::zfn_out_t                             res_o
);
  import zfn_pkg::*;

  zfn_out_t res_q;
  logic     valid_q;

  // strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit_i;
    end
  end

  // gather the lanes into one result beat
  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      res_q.norm0       <= norm_i[0];
      res_q.norm1       <= norm_i[1];
      res_q.norm2       <= norm_i[2];
      res_q.norm3       <= norm_i[3];
      res_q.norm4       <= norm_i[4];
      res_q.norm5       <= norm_i[5];
      res_q.norm6       <= norm_i[6];
      res_q.result_last <= last_i;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* src/zscore_feature_normalizer.sv */
// Z-score normalizer for sets of up to MaxVectors seven-dimensional Q12.12
// vectors. While busy is low a beat is taken each cycle start is high; each
// beat is stored and summed as it is taken. The beat with set_last (or any
// beat arriving with the store full, whose values are dropped) closes the set
// and raises busy. Seven lanes, one per dimension, then run in step: a mean
// division, a variance pass that reads, squares and accumulates each vector
// in turn, a variance division, a square root and one division per vector
// for the output, each division run by the one-bit-per-cycle divider in each
// lane. Results come out one beat per vector, each strobed by res_valid_o for
// one cycle, which must be taken then; the last carries result_last and busy
// falls in that same cycle.
module zscore_feature_normalizer #(
  parameter int unsigned MaxVectors = zfn_pkg::MaxVectors
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  zfn_pkg::zfn_in_t   item_i,
  output logic               res_valid_o,
  output zfn_pkg::zfn_out_t  res_o
);
  import zfn_pkg::*;

  localparam int unsigned AddrW = (MaxVectors > 1) ? $clog2(MaxVectors) : 1;
  localparam int unsigned CntW  = $clog2(MaxVectors + 1);

  typedef enum logic [12:0] {
    ST_LOAD     = 13'b0000000000001,
    ST_MEAN_GO  = 13'b0000000000010,
    ST_MEAN_WT  = 13'b0000000000100,
    ST_VAR_RD   = 13'b0000000001000,
    ST_VAR_SQ   = 13'b0000000010000,
    ST_VAR_ACC  = 13'b0000000100000,
    ST_VDIV_GO  = 13'b0000001000000,
    ST_VDIV_WT  = 13'b0000010000000,
    ST_SQRT_GO  = 13'b0000100000000,
    ST_SQRT_WT  = 13'b0001000000000,
    ST_NORM_RD  = 13'b0010000000000,
    ST_NORM_GO  = 13'b0100000000000,
    ST_NORM_WT  = 13'b1000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d, cnt_m1;
  logic [AddrW-1:0] k_q, k_d, addr;
  logic            accept, full, k_last, emit;
  logic            div_done_all, sqrt_done_all;
  zfn_ctrl_t       ctrl;
  zfn_stat_t       stat [Dims];
  logic [Dims-1:0] div_done_v, sqrt_done_v;
  logic [Dims-1:0][ValW-1:0] norms;
  logic signed [ValW-1:0] vals [Dims];

  assign accept = start && !busy;
  assign full   = count_q == CntW'(MaxVectors);
  assign cnt_m1 = count_q - CntW'(1);
  assign k_last = CntW'(k_q) == cnt_m1;
  assign addr   = (state_q == ST_LOAD) ? count_q[AddrW-1:0] : k_q;

  assign vals[0] = item_i.dim0_value;
  assign vals[1] = item_i.dim1_value;
  assign vals[2] = item_i.dim2_value;
  assign vals[3] = item_i.dim3_value;
  assign vals[4] = item_i.dim4_value;
  assign vals[5] = item_i.dim5_value;
  assign vals[6] = item_i.dim6_value;

  // one lane per dimension
  for (genvar g = 0; g < Dims; g++) begin : g_lane
    zfn_lane #(
      .MaxVectors (MaxVectors)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .addr_i  (addr),
      .value_i (vals[g]),
      .count_i (count_q),
      .stat_o  (stat[g]),
      .norm_o  (norms[g])
    );
    assign div_done_v[g]  = stat[g].div_done;
    assign sqrt_done_v[g] = stat[g].sqrt_done;
  end

  assign div_done_all  = &div_done_v;
  assign sqrt_done_all = &sqrt_done_v;

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    k_d          = k_q;
    ctrl         = '0;
    ctrl.sel     = SEL_MEAN;
    emit         = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (!full) begin
            ctrl.wr = 1'b1;
            count_d = count_q + CntW'(1);
          end
          if (item_i.set_last || full) begin
            state_d = ST_MEAN_GO;
          end
        end
      end
      ST_MEAN_GO: begin
        ctrl.div_go = 1'b1;
        ctrl.sel    = SEL_MEAN;
        state_d     = ST_MEAN_WT;
      end
      ST_MEAN_WT: begin
        if (div_done_all) begin
          k_d     = '0;
          state_d = ST_VAR_RD;
        end
      end
      ST_VAR_RD: begin
        state_d = ST_VAR_SQ;
      end
      ST_VAR_SQ: begin
        ctrl.sq = 1'b1;
        state_d = ST_VAR_ACC;
      end
      ST_VAR_ACC: begin
        ctrl.acc = 1'b1;
        if (k_last) begin
          state_d = ST_VDIV_GO;
        end else begin
          k_d     = k_q + AddrW'(1);
          state_d = ST_VAR_RD;
        end
      end
      ST_VDIV_GO: begin
        ctrl.div_go = 1'b1;
        ctrl.sel    = SEL_VAR;
        state_d     = ST_VDIV_WT;
      end
      ST_VDIV_WT: begin
        if (div_done_all) begin
          state_d = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        ctrl.sqrt_go = 1'b1;
        state_d      = ST_SQRT_WT;
      end
      ST_SQRT_WT: begin
        if (sqrt_done_all) begin
          k_d     = '0;
          state_d = ST_NORM_RD;
        end
      end
      ST_NORM_RD: begin
        state_d = ST_NORM_GO;
      end
      ST_NORM_GO: begin
        ctrl.div_go = 1'b1;
        ctrl.sel    = SEL_NORM;
        state_d     = ST_NORM_WT;
      end
      ST_NORM_WT: begin
        ctrl.sel = SEL_NORM;
        if (div_done_all) begin
          emit = 1'b1;
          if (k_last) begin
            ctrl.clear = 1'b1;
            count_d    = '0;
            state_d    = ST_LOAD;
          end else begin
            k_d     = k_q + AddrW'(1);
            state_d = ST_NORM_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
    end
  end

  assign busy = state_q != ST_LOAD;

  // output beat register
  zfn_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .last_i      (k_last),
    .norm_i      (norms),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // leaving the busy phase delivers the last beat of the set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.result_last)
    else $error("set closed without its last beat");

  // a last beat only appears as the block goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_last |-> !busy)
    else $error("last beat while still busy");

  // beats never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back to back result beats");

  // lanes stay in lock step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done_v == '0) || (div_done_v == '1))
    else $error("lanes out of step");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import zfn_pkg::*;

  localparam int unsigned SetMax = 64;

  // golden model of the normalizer plus queue of expected beats
  class zscore_scoreboard;
    logic signed [ValW-1:0] vec_store[SetMax][Dims];
    int unsigned            vec_count;
    longint                 dim_sum[Dims];
    zfn_out_t               norm_q[$];
    int unsigned            mismatches;

    function void clear_set();
      vec_count = 0;
      foreach (dim_sum[d]) dim_sum[d] = 0;
    endfunction

    function logic signed [ValW-1:0] field_of(zfn_in_t b, int d);
      case (d)
        0: return b.dim0_value;
        1: return b.dim1_value;
        2: return b.dim2_value;
        3: return b.dim3_value;
        4: return b.dim4_value;
        5: return b.dim5_value;
        default: return b.dim6_value;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // note an accepted input beat, predict results when the set closes
    function void note_input(zfn_in_t b);
      logic closing;
      longint mean[Dims];
      longint divisor[Dims];
      longint unsigned sq;
      longint diff;
      longint q;
      logic signed [ValW-1:0] nv[Dims];
      zfn_out_t r;
      closing = b.set_last;
      if (vec_count >= SetMax) begin
        closing = 1'b1;
      end else begin
        for (int d = 0; d < Dims; d++) begin
          vec_store[vec_count][d] = field_of(b, d);
          dim_sum[d] += longint'(field_of(b, d));
        end
        vec_count++;
      end
      if (!closing) return;
      for (int d = 0; d < Dims; d++) begin
        mean[d] = dim_sum[d] / longint'(vec_count);
        sq = 0;
        for (int k = 0; k < vec_count; k++) begin
          diff = longint'(vec_store[k][d]) - mean[d];
          if (diff < 0) diff = -diff;
          sq += longint'(diff) * longint'(diff);
        end
        divisor[d] = longint'(int_sqrt(sq / vec_count));
        if (divisor[d] == 0) divisor[d] = 1;
      end
      for (int k = 0; k < vec_count; k++) begin
        for (int d = 0; d < Dims; d++) begin
          diff = longint'(vec_store[k][d]) - mean[d];
          q = (diff * 4096) / divisor[d];
          if (q > 8388607) q = 8388607;
          if (q < -8388608) q = -8388608;
          nv[d] = q[ValW-1:0];
        end
        r = '{nv[0], nv[1], nv[2], nv[3], nv[4], nv[5], nv[6],
              (k + 1 == vec_count)};
        norm_q.insert(norm_q.size(), r);
      end
      clear_set();
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, actual %0d", name, e, a);
        mismatches++;
      end
    endfunction

    // check one result beat against the oldest prediction
    function void check_result(zfn_out_t a);
      zfn_out_t e;
      if (norm_q.size() == 0) begin
        $error("result_beat: expected none, actual %h", a);
        mismatches++;
        return;
      end
      e = norm_q.pop_front();
      cmp("norm0", e.norm0, a.norm0);
      cmp("norm1", e.norm1, a.norm1);
      cmp("norm2", e.norm2, a.norm2);
      cmp("norm3", e.norm3, a.norm3);
      cmp("norm4", e.norm4, a.norm4);
      cmp("norm5", e.norm5, a.norm5);
      cmp("norm6", e.norm6, a.norm6);
      cmp("result_last", e.result_last, a.result_last);
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  zfn_in_t  item_i;
  logic     res_valid_o;
  zfn_out_t res_o;

  zscore_scoreboard sb;
  longint unsigned  cycle_cnt;
  bit               no_idle;

  zscore_feature_normalizer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sample results and run the cycle limit
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
    cycle_cnt++;
    if (cycle_cnt > 64'd3_000_000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // drive one beat and hold until accepted, start stays high afterwards
  task automatic send_beat(zfn_in_t b);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= b;
    do @(posedge clk_i); while (busy);
    sb.note_input(b);
    @(negedge clk_i);
  endtask

  // wait at falling edges until every predicted beat has come
  task automatic drain();
    while (sb.norm_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [ValW-1:0] rand_val(int mode);
    case (mode)
      0: return ValMax;
      1: return ValMin;
      2: return ValW'($urandom_range(0, 8191) - 4096);
      default: return ValW'($urandom());
    endcase
  endfunction

  function automatic zfn_in_t rand_beat(logic last, int mode);
    zfn_in_t b;
    b.dim0_value = rand_val(mode == 9 ? $urandom_range(0, 3) : mode);
    b.dim1_value = rand_val(mode == 9 ? $urandom_range(0, 3) : mode);
    b.dim2_value = rand_val(mode == 9 ? $urandom_range(0, 3) : mode);
    b.dim3_value = rand_val(mode == 9 ? $urandom_range(0, 3) : mode);
    b.dim4_value = rand_val(mode == 9 ? $urandom_range(0, 3) : mode);
    b.dim5_value = 24'sd77;
    b.dim6_value = rand_val(mode == 9 ? $urandom_range(0, 3) : mode);
    if (mode == 9 && $urandom_range(0, 1)) b.dim5_value = rand_val(3);
    b.set_last = last;
    return b;
  endfunction

  initial begin
    int unsigned set_len;
    sb = new();
    sb.clear_set();
    sb.mismatches = 0;
    cycle_cnt = 0;
    no_idle = 1'b1;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: single vector, extremes, mixed
    send_beat(rand_beat(1'b1, 0));
    send_beat(rand_beat(1'b0, 0));
    send_beat(rand_beat(1'b1, 1));
    send_beat(rand_beat(1'b0, 1));
    send_beat(rand_beat(1'b0, 1));
    send_beat(rand_beat(1'b1, 0));
    for (int i = 0; i < 6; i++) send_beat(rand_beat(i == 5, 9));

    // directed: full store, then an overflow beat closes the set
    for (int i = 0; i < SetMax; i++) send_beat(rand_beat(1'b0, 2));
    send_beat(rand_beat(1'b0, 3));
    start <= 1'b0;

    // pause until every expected beat is out
    drain();
    @(negedge clk_i);

    // random sets, mostly small
    no_idle = 1'b0;
    for (int s = 0; s < 14; s++) begin
      set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
      if (s >= 11) no_idle = 1'b1;
      for (int i = 0; i < set_len; i++)
        send_beat(rand_beat(i == set_len - 1, $urandom_range(0, 4) == 0 ? 3 : 9));
    end
    start <= 1'b0;

    drain();
    repeat (200) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.norm_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/zfn_pkg.sv
src/zfn_ram.sv
src/zfn_div.sv
src/zfn_lane.sv
src/zfn_merge.sv
src/zscore_feature_normalizer.sv
test/tb_top.sv
